FILE: sv/signed_int32_divider_unit_defines.svh
// ----------------------------------------------------------------------------
// signed_int32_divider_unit assertion macros
// Shared concurrent assertion forms for the divider checker.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT32_DIVIDER_UNIT_DEFINES_SVH
`define SIGNED_INT32_DIVIDER_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define SDIV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define SDIV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, live during reset
`define SDIV_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/sdiv_pkg.sv
// ----------------------------------------------------------------------------
// sdiv_pkg
// Types, constants and helpers shared by the signed 32-bit divider.
// ----------------------------------------------------------------------------
`default_nettype none

package sdiv_pkg;

  localparam int unsigned DW     = 32;
  localparam int unsigned NSTEPS = DW;

  localparam logic [DW-1:0] SAT_VAL = {1'b0, {(DW-1){1'b1}}};

  // one pipeline slot: num starts as |dividend| and fills with quotient bits
  typedef struct packed {
    logic          valid;
    logic          neg;
    logic          sat;
    logic [DW-1:0] rem;
    logic [DW-1:0] num;
    logic [DW-1:0] den;
  } sdiv_stage_t;

  function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
    mag = v[DW-1] ? (~v + {{(DW-1){1'b0}}, 1'b1}) : v;
  endfunction

endpackage

`default_nettype wire

FILE: sv/sdiv_prep.sv
// ----------------------------------------------------------------------------
// sdiv_prep
// Input stage: operand magnitudes, quotient sign and saturation cases.
// ----------------------------------------------------------------------------
`default_nettype none

module sdiv_prep (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [sdiv_pkg::DW-1:0]   dividend,
  input  wire logic [sdiv_pkg::DW-1:0]   divisor,
  output sdiv_pkg::sdiv_stage_t          stg_o
);
  import sdiv_pkg::*;

  sdiv_stage_t stg_r;
  sdiv_stage_t stg_nxt;
  logic        div_zero;
  logic        min_by_m1;

  always_comb begin
    div_zero  = (divisor == '0);
    min_by_m1 = (dividend == {1'b1, {(DW-1){1'b0}}}) && (divisor == {DW{1'b1}});
    stg_nxt.valid = in_valid;
    stg_nxt.neg   = dividend[DW-1] ^ divisor[DW-1];
    stg_nxt.sat   = div_zero | min_by_m1;
    stg_nxt.rem   = '0;
    stg_nxt.num   = mag(dividend);
    stg_nxt.den   = mag(divisor);
  end

  // only the valid bit is reset; payload follows the enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.valid <= 1'b0;
    end else if (en) begin
      stg_r.valid <= stg_nxt.valid;
    end
    if (en) begin
      stg_r.neg <= stg_nxt.neg;
      stg_r.sat <= stg_nxt.sat;
      stg_r.rem <= stg_nxt.rem;
      stg_r.num <= stg_nxt.num;
      stg_r.den <= stg_nxt.den;
    end
  end

  assign stg_o = stg_r;

endmodule

`default_nettype wire

FILE: sv/sdiv_step.sv
// ----------------------------------------------------------------------------
// sdiv_step
// One restoring shift-subtract step: settles one quotient bit, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sdiv_step (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire sdiv_pkg::sdiv_stage_t stg_i,
  output sdiv_pkg::sdiv_stage_t      stg_o
);
  import sdiv_pkg::*;

  sdiv_stage_t   stg_r;
  sdiv_stage_t   stg_nxt;
  logic [DW:0]   trial;
  logic [DW+1:0] diff;
  logic          ge;

  always_comb begin
    trial = {stg_i.rem, stg_i.num[DW-1]};
    diff  = {1'b0, trial} - {2'b00, stg_i.den};
    ge    = ~diff[DW+1];
    stg_nxt       = stg_i;
    // remainder stays below a nonzero den, so DW bits always hold it
    stg_nxt.rem   = ge ? diff[DW-1:0] : trial[DW-1:0];
    stg_nxt.num   = {stg_i.num[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.valid <= 1'b0;
    end else if (en) begin
      stg_r.valid <= stg_nxt.valid;
    end
    if (en) begin
      stg_r.neg <= stg_nxt.neg;
      stg_r.sat <= stg_nxt.sat;
      stg_r.rem <= stg_nxt.rem;
      stg_r.num <= stg_nxt.num;
      stg_r.den <= stg_nxt.den;
    end
  end

  assign stg_o = stg_r;

endmodule

`default_nettype wire

FILE: sv/sdiv_fix.sv
// ----------------------------------------------------------------------------
// sdiv_fix
// Output stage: sign fix-up, saturation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdiv_fix (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire sdiv_pkg::sdiv_stage_t   stg_i,
  output logic                         out_valid,
  output logic [sdiv_pkg::DW-1:0]      quotient,
  output logic                         overflow
);
  import sdiv_pkg::*;

  logic          valid_r;
  logic [DW-1:0] quo_r;
  logic [DW-1:0] quo_nxt;
  logic          ovf_r;

  always_comb begin
    if (stg_i.sat) begin
      quo_nxt = SAT_VAL;
    end else if (stg_i.neg) begin
      quo_nxt = ~stg_i.num + {{(DW-1){1'b0}}, 1'b1};
    end else begin
      quo_nxt = stg_i.num;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= stg_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
      ovf_r <= stg_i.sat;
    end
  end

  assign out_valid = valid_r;
  assign quotient  = quo_r;
  assign overflow  = ovf_r;

endmodule

`default_nettype wire

FILE: sv/signed_int32_divider_unit.sv
// ----------------------------------------------------------------------------
// signed_int32_divider_unit
// Signed 32-bit divider, quotient truncated toward zero, fully pipelined.
// ----------------------------------------------------------------------------
// The unit takes one dividend/divisor pair per cycle while the output is not
// stalled and passes each through registered stages: an input stage forms
// magnitudes and flags the saturating cases, 32 one-bit shift-subtract stages
// settle the quotient from the top bit down, and an output stage applies the
// sign and holds the result. Sustained throughput is one transfer per cycle;
// a stall on the output freezes the whole pipeline and drops in_ready in the
// same cycle. Division by zero and the most negative value divided by -1
// return 2147483647 with out_overflow set. No remainder is produced.
`default_nettype none

module signed_int32_divider_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [sdiv_pkg::DW-1:0] in_dividend,
  input  wire logic signed [sdiv_pkg::DW-1:0] in_divisor,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [sdiv_pkg::DW-1:0]      out_quotient,
  output logic                                out_overflow
);
  import sdiv_pkg::*;

  sdiv_stage_t   pipe [0:NSTEPS];
  logic          en;
  logic [DW-1:0] quo;

  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  sdiv_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .dividend (in_dividend),
    .divisor  (in_divisor),
    .stg_o    (pipe[0])
  );

  for (genvar g = 0; g < NSTEPS; g++) begin : g_step
    sdiv_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .stg_i (pipe[g]),
      .stg_o (pipe[g+1])
    );
  end

  sdiv_fix u_fix (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .stg_i     (pipe[NSTEPS]),
    .out_valid (out_valid),
    .quotient  (quo),
    .overflow  (out_overflow)
  );

  assign out_quotient = quo;

endmodule

`default_nettype wire

FILE: sv/sdiv_checker.sv
// ----------------------------------------------------------------------------
// sdiv_checker
// Port-level assertions for signed_int32_divider_unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "signed_int32_divider_unit_defines.svh"

module sdiv_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [sdiv_pkg::DW-1:0]   out_quotient,
  input wire logic                      out_overflow
);
  import sdiv_pkg::*;

  `SDIV_ASSERT_ALWAYS(a_rst_clears, !rst_n, !out_valid, "out_valid after reset")
  `SDIV_ASSERT_NOW(a_ovf_sat, out_valid && out_overflow,
                   out_quotient == SAT_VAL, "overflow without saturated quotient")
  `SDIV_ASSERT_NOW(a_stall_blocks, out_valid && !out_ready, !in_ready,
                   "input taken while output stalled")
  `SDIV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_quotient) && $stable(out_overflow),
                    "stalled result changed")

endmodule

bind signed_int32_divider_unit sdiv_checker u_sdiv_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_quotient (out_quotient),
  .out_overflow (out_overflow)
);

`default_nettype wire
